### src/igb_pkg.sv
// ----------------------------------------------------------------------------
// igb_pkg: shared types and codes of the idle-gap burst receive buffer
// Command and status codes, burst limits and the payload structs of the
// input and result channels.
// ----------------------------------------------------------------------------
package igb_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CMD_WORD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  // Burst limits and register reset values.
  localparam int unsigned LEN_W     = 6;
  localparam logic [7:0]  MAX_OUT   = 8'd32;
  localparam logic [7:0]  MIN_BURST = 8'd2;
  localparam logic [15:0] GAP_RESET = 16'd500;
  localparam logic [15:0] IDLE_SAT  = 16'hFFFF;

  // Payload of an input item.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] rx_word;
    logic [7:0]  max_words;
  } in_item_t;

  // Payload of a result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data_word;
    logic [6:0]  burst_length;
    logic        last;
  } out_item_t;

endpackage

### src/idle_gap_burst_receive_buffer_top.sv
// ----------------------------------------------------------------------------
// idle_gap_burst_receive_buffer_top: idle-gap framed receive ring
// Stores received words in a ring, marks burst starts by idle gaps and
// streams the current burst on a read request.
// ----------------------------------------------------------------------------
// A read passes the job queue, the read stage and the output register
// before its first result item is valid; word and tick items give no
// result. Throughput: one item per cycle in while in_stall_o is low; a
// burst streams one word per cycle from the ring's single read port while
// out_stall_i is low. A word item waits until every pending read has read the ring.
// Reset: indexes clear, the idle count saturates, idle_gap is 500; ring
// contents stay undefined until written.
module idle_gap_burst_receive_buffer_top #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  igb_pkg::in_item_t  in_item_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output igb_pkg::out_item_t out_item_o,
  input  logic               out_stall_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned QW = 2 + IW + igb_pkg::LEN_W;

  logic          back_active;
  logic          q_empty;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [15:0]   wr_data;

  // Intake and classification.
  igb_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .back_active_i(back_active),
    .q_empty_i    (q_empty),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_wdata_o    (q_wdata),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  // Job queue between the two sides.
  igb_queue #(
    .W(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // Ring storage and result streaming.
  igb_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_rdata_i  (q_rdata),
    .q_pop_o    (q_pop),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .active_o   (back_active),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

endmodule

### src/igb_queue.sv
// ----------------------------------------------------------------------------
// igb_queue: two-entry job queue
// Holds read jobs between the front and the back so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module igb_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o,
  output logic         full_o
);

  logic [W-1:0] entry_q [2];
  logic         wp_q, wp_d;
  logic         rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;

  assign rdata_o = entry_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  // Pointer and fill count update.
  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= wdata_i;
    end
  end

endmodule

### src/igb_front.sv
// ----------------------------------------------------------------------------
// igb_front: item intake and classification
// Tracks the write index, the burst start and the idle count, sends
// received words to the ring and turns each read into a queued job.
// ----------------------------------------------------------------------------
module igb_front #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  igb_pkg::in_item_t  in_item_i,
  output logic               in_stall_o,
  input  logic               back_active_i,
  input  logic               q_empty_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output logic [2+$clog2(DEPTH)+igb_pkg::LEN_W-1:0] q_wdata_o,
  output logic               wr_en_o,
  output logic [$clog2(DEPTH)-1:0] wr_addr_o,
  output logic [15:0]        wr_data_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned LW = IW + 1;

  typedef struct packed {
    logic [1:0]                kind;
    logic [IW-1:0]             start;
    logic [igb_pkg::LEN_W-1:0] len;
  } job_t;

  logic [15:0]   gap_q;
  logic [15:0]   idle_q, idle_d;
  logic [IW-1:0] wi_q, wi_d;
  logic [IW-1:0] bs_q, bs_d;
  logic [IW-1:0] re_q, re_d;

  logic          accept;
  logic          ring_free;
  logic          line_idle;
  logic [IW-1:0] wi_next;
  logic [IW-1:0] start;
  logic [LW-1:0] end_x;
  logic [LW-1:0] span;
  logic [7:0]    len_a;
  logic [7:0]    len_b;
  logic [7:0]    len_c;
  job_t          job;

  // Words go to the ring only when no read job is pending or running.
  assign ring_free  = q_empty_i && !back_active_i;
  assign in_stall_o = q_full_i ||
                      ((in_item_i.command == igb_pkg::CMD_WORD) && !ring_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign line_idle  = (idle_q > gap_q);

  assign wi_next = (wi_q == IW'(DEPTH - 1)) ? '0 : wi_q + 1'b1;

  // Burst span and clamping for a read.
  always_comb begin
    start = (re_q == wi_q) ? re_q : bs_q;
    end_x = (wi_q < start) ? ({1'b0, wi_q} + LW'(DEPTH)) : {1'b0, wi_q};
    span  = end_x - {1'b0, start} + 1'b1;
    len_a = 8'(span);
    len_b = (len_a > in_item_i.max_words) ? in_item_i.max_words : len_a;
    len_c = (len_b > igb_pkg::MAX_OUT) ? igb_pkg::MAX_OUT : len_b;
  end

  // Job built for the queue.
  always_comb begin
    job.start = start;
    job.len   = igb_pkg::LEN_W'(len_c);
    if (!line_idle) begin
      job.kind = igb_pkg::ST_BUSY;
    end else if (len_c < igb_pkg::MIN_BURST) begin
      job.kind = igb_pkg::ST_NONE;
    end else begin
      job.kind = igb_pkg::ST_DATA;
    end
  end

  assign q_wdata_o = job;
  assign q_push_o  = accept && (in_item_i.command == igb_pkg::CMD_READ);

  assign wr_en_o   = accept && (in_item_i.command == igb_pkg::CMD_WORD);
  assign wr_addr_o = wi_next;
  assign wr_data_o = in_item_i.rx_word;

  // Next state per command.
  always_comb begin
    idle_d = idle_q;
    wi_d   = wi_q;
    bs_d   = bs_q;
    re_d   = re_q;
    if (accept) begin
      case (in_item_i.command)
        igb_pkg::CMD_WORD: begin
          wi_d   = wi_next;
          idle_d = '0;
          if (line_idle) begin
            bs_d = wi_next;
          end
        end
        igb_pkg::CMD_TICK: begin
          if (idle_q != igb_pkg::IDLE_SAT) begin
            idle_d = idle_q + 16'd1;
          end
        end
        igb_pkg::CMD_READ: begin
          if (line_idle) begin
            re_d = wi_q;
          end
        end
        default: begin
          idle_d = idle_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q  <= igb_pkg::GAP_RESET;
      idle_q <= igb_pkg::IDLE_SAT;
      wi_q   <= '0;
      bs_q   <= '0;
      re_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      idle_q <= idle_d;
      wi_q   <= wi_d;
      bs_q   <= bs_d;
      re_q   <= re_d;
    end
  end

endmodule

### src/igb_back.sv
// ----------------------------------------------------------------------------
// igb_back: ring storage and result streaming
// Holds the word ring, takes read jobs from the queue and streams the
// result items through a read stage and an output register.
// ----------------------------------------------------------------------------
module igb_back #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  logic [2+$clog2(DEPTH)+igb_pkg::LEN_W-1:0] q_rdata_i,
  output logic               q_pop_o,
  input  logic               wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [15:0]        wr_data_i,
  output logic               active_o,
  output logic               out_valid_o,
  output igb_pkg::out_item_t out_item_o,
  input  logic               out_stall_i
);

  localparam int unsigned IW = $clog2(DEPTH);

  typedef struct packed {
    logic [1:0]                kind;
    logic [IW-1:0]             start;
    logic [igb_pkg::LEN_W-1:0] len;
  } job_t;

  logic [15:0] ring_mem [DEPTH];

  job_t                      job;
  logic                      adv;
  logic                      active_q;
  logic [IW-1:0]             slot_q;
  logic [igb_pkg::LEN_W-1:0] idx_q;
  logic [igb_pkg::LEN_W-1:0] len_q;

  // Issue slot signals.
  logic                      iss_valid;
  logic                      iss_data;
  logic [1:0]                iss_status;
  logic [IW-1:0]             iss_slot;
  logic [igb_pkg::LEN_W-1:0] iss_len;
  logic                      iss_last;
  logic [IW-1:0]             iss_slot_next;

  // Read stage.
  logic                      s1_valid_q;
  logic                      s1_data_q;
  logic [1:0]                s1_status_q;
  logic [igb_pkg::LEN_W-1:0] s1_len_q;
  logic                      s1_last_q;
  logic [15:0]               rd_q;

  // Output register.
  logic                      out_valid_q;
  igb_pkg::out_item_t        out_item_q;

  assign job         = q_rdata_i;
  assign adv         = !out_valid_q || !out_stall_i;
  assign active_o    = active_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Pick the next result to issue: a running burst first, else a new job.
  always_comb begin
    iss_valid  = 1'b0;
    iss_data   = 1'b0;
    iss_status = igb_pkg::ST_DATA;
    iss_slot   = slot_q;
    iss_len    = len_q;
    iss_last   = 1'b0;
    q_pop_o    = 1'b0;
    if (active_q) begin
      iss_valid = 1'b1;
      iss_data  = 1'b1;
      iss_last  = (idx_q == len_q - 1'b1);
    end else if (!q_empty_i) begin
      iss_valid  = 1'b1;
      q_pop_o    = adv;
      iss_status = job.kind;
      if (job.kind == igb_pkg::ST_DATA) begin
        iss_data = 1'b1;
        iss_slot = job.start;
        iss_len  = job.len;
      end else begin
        iss_len  = '0;
        iss_last = 1'b1;
      end
    end
  end

  assign iss_slot_next = (iss_slot == IW'(DEPTH - 1)) ? '0 : iss_slot + 1'b1;

  // Burst sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      slot_q   <= '0;
      idx_q    <= '0;
      len_q    <= '0;
    end else if (adv) begin
      if (active_q) begin
        slot_q <= iss_slot_next;
        idx_q  <= idx_q + 1'b1;
        if (iss_last) begin
          active_q <= 1'b0;
        end
      end else if (!q_empty_i && (job.kind == igb_pkg::ST_DATA)) begin
        active_q <= 1'b1;
        slot_q   <= iss_slot_next;
        idx_q    <= igb_pkg::LEN_W'(1);
        len_q    <= job.len;
      end
    end
  end

  // Ring memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ring_mem[wr_addr_i] <= wr_data_i;
    end
    if (adv) begin
      rd_q <= ring_mem[iss_slot];
    end
  end

  // Read stage control and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= iss_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_data_q   <= iss_data;
      s1_status_q <= iss_status;
      s1_len_q    <= iss_len;
      s1_last_q   <= iss_last;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q.status       <= s1_status_q;
      out_item_q.data_word    <= s1_data_q ? rd_q : 16'd0;
      out_item_q.burst_length <= 7'(s1_len_q);
      out_item_q.last         <= s1_last_q;
    end
  end

endmodule
